/* hdl/fixed_point_euler_rotate_macros.svh */
// Assertion macros for the Euler rotation block.
// Used by the controller; clocked on clk_i and disabled while rst_ni is low.
`ifndef FIXED_POINT_EULER_ROTATE_MACROS_SVH
`define FIXED_POINT_EULER_ROTATE_MACROS_SVH

// Same-cycle implication.
`define FPER_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FPER_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fper_pkg.sv */
// Shared types, constants, sine table and step tables for the Euler rotation block.
// No dependencies; used by fper_ctrl, fper_datapath and the top level.
`timescale 1ns / 1ps
package fper_pkg;

  localparam int unsigned AngleSteps = 1024;
  localparam int unsigned ScaleLog2  = 14;

  localparam int unsigned AngW   = 10;
  localparam int unsigned VecW   = 32;
  localparam int unsigned OutW   = 49;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned RfW    = 17;

  localparam int unsigned RomLen  = (AngleSteps * 5) / 4;
  localparam int unsigned RomAw   = $clog2(RomLen);
  localparam int unsigned Quarter = AngleSteps / 4;

  localparam int unsigned LoadSteps  = 14;
  localparam int unsigned XformSteps = 9;
  localparam int unsigned RomReads   = 6;
  localparam int unsigned FirstFinal = 6;

  localparam longint unsigned PiQ60 = 64'h3243F6A8885A308D;
  localparam longint unsigned D2    = 2 * AngleSteps;
  // Divisors (k+1)*(k+2) of the sine series for odd k from 1 to 39.
  localparam longint unsigned SeriesDiv [20] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056,
    64'd1190, 64'd1332, 64'd1482, 64'd1640};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    RF_SX = 3'd0,
    RF_SY = 3'd1,
    RF_SZ = 3'd2,
    RF_CX = 3'd3,
    RF_CY = 3'd4,
    RF_CZ = 3'd5,
    RF_T1 = 3'd6,
    RF_T2 = 3'd7
  } rf_sel_e;

  typedef enum logic [3:0] {
    D_XX = 4'd0,
    D_XY = 4'd1,
    D_XZ = 4'd2,
    D_YX = 4'd3,
    D_YY = 4'd4,
    D_YZ = 4'd5,
    D_ZX = 4'd6,
    D_ZZ = 4'd8,
    D_T1 = 4'd9,
    D_T2 = 4'd10
  } dest_e;

  // The zy coefficient is sin(x) itself and is copied straight from the table.
  localparam logic [3:0] CoefZyIdx = 4'd7;

  typedef enum logic [2:0] {
    DP_NONE    = 3'd0,
    DP_CAPTURE = 3'd1,
    DP_REDUCE  = 3'd2,
    DP_ROM     = 3'd3,
    DP_LMUL    = 3'd4,
    DP_LACC    = 3'd5,
    DP_XMUL    = 3'd6,
    DP_XACC    = 3'd7
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic reduce_done;
  } dp_status_t;

  typedef struct packed {
    rf_sel_e a;
    rf_sel_e b;
    logic    neg;
    logic    first;
    logic    last;
    dest_e   dest;
  } load_step_t;

  typedef struct packed {
    logic [1:0] vec;
    logic [1:0] lane;
  } xform_step_t;

  typedef struct packed {
    logic [1:0] ang;
    logic       cos;
    rf_sel_e    dst;
  } rom_step_t;

  typedef logic signed [CoefW-1:0] sine_rom_t [RomLen];

  function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic signed [CoefW-1:0] sine_entry(int unsigned t);
    longint unsigned u;
    longint unsigned n;
    longint unsigned mag;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    logic            neg;
    logic            sub;
    logic            done;
    logic signed [CoefW-1:0] res;
    n    = AngleSteps;
    u    = 4 * (t % AngleSteps);
    neg  = 1'b0;
    sub  = 1'b1;
    done = 1'b0;
    if (u >= 2 * n) begin
      neg = 1'b1;
      u   = u - 2 * n;
    end
    if (u > n) u = 2 * n - u;
    if (u == 0) begin
      mag = 0;
    end else if (u == n) begin
      mag = 64'd1 << ScaleLog2;
    end else if (3 * u == n) begin
      mag = 64'd1 << (ScaleLog2 - 1);
    end else begin
      x    = (PiQ60 / D2) * u + ((PiQ60 % D2) * u) / D2;
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int i = 0; i < 20; i++) begin
        if (!done) begin
          term = mul_q60(term, x2) / SeriesDiv[i];
          if (term == 0) begin
            done = 1'b1;
          end else begin
            if (sub) sum = sum - term;
            else     sum = sum + term;
            sub = !sub;
          end
        end
      end
      mag = sum >> (60 - ScaleLog2);
    end
    res = CoefW'(mag);
    if (neg) res = -res;
    return res;
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    for (int unsigned i = 0; i < RomLen; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_rom();

  // Coefficient program: each step is one product added to or subtracted
  // from the running sum; the last step of a term divides by the scale.
  function automatic load_step_t load_step(logic [3:0] s);
    load_step_t ls;
    case (s)
      4'd0:    ls = '{RF_SX, RF_SY, 1'b0, 1'b1, 1'b1, D_T1};
      4'd1:    ls = '{RF_SX, RF_CY, 1'b0, 1'b1, 1'b1, D_T2};
      4'd2:    ls = '{RF_CY, RF_CZ, 1'b0, 1'b1, 1'b0, D_XX};
      4'd3:    ls = '{RF_T1, RF_SZ, 1'b0, 1'b0, 1'b1, D_XX};
      4'd4:    ls = '{RF_CX, RF_SZ, 1'b1, 1'b1, 1'b1, D_XY};
      4'd5:    ls = '{RF_SY, RF_CZ, 1'b1, 1'b1, 1'b0, D_XZ};
      4'd6:    ls = '{RF_T2, RF_SZ, 1'b0, 1'b0, 1'b1, D_XZ};
      4'd7:    ls = '{RF_CY, RF_SZ, 1'b0, 1'b1, 1'b0, D_YX};
      4'd8:    ls = '{RF_T1, RF_CZ, 1'b1, 1'b0, 1'b1, D_YX};
      4'd9:    ls = '{RF_CX, RF_CZ, 1'b0, 1'b1, 1'b1, D_YY};
      4'd10:   ls = '{RF_SY, RF_SZ, 1'b1, 1'b1, 1'b0, D_YZ};
      4'd11:   ls = '{RF_T2, RF_CZ, 1'b1, 1'b0, 1'b1, D_YZ};
      4'd12:   ls = '{RF_CX, RF_SY, 1'b0, 1'b1, 1'b1, D_ZX};
      4'd13:   ls = '{RF_CX, RF_CY, 1'b0, 1'b1, 1'b1, D_ZZ};
      default: ls = '{RF_SX, RF_SX, 1'b0, 1'b1, 1'b0, D_XX};
    endcase
    return ls;
  endfunction

  // Transform step s uses coefficient s, vector component s/3, output lane s%3.
  function automatic xform_step_t xform_step(logic [3:0] s);
    xform_step_t xs;
    case (s)
      4'd0:    xs = '{2'd0, 2'd0};
      4'd1:    xs = '{2'd0, 2'd1};
      4'd2:    xs = '{2'd0, 2'd2};
      4'd3:    xs = '{2'd1, 2'd0};
      4'd4:    xs = '{2'd1, 2'd1};
      4'd5:    xs = '{2'd1, 2'd2};
      4'd6:    xs = '{2'd2, 2'd0};
      4'd7:    xs = '{2'd2, 2'd1};
      4'd8:    xs = '{2'd2, 2'd2};
      default: xs = '{2'd0, 2'd0};
    endcase
    return xs;
  endfunction

  function automatic rom_step_t rom_step(logic [3:0] s);
    rom_step_t rs;
    case (s)
      4'd0:    rs = '{2'd0, 1'b0, RF_SX};
      4'd1:    rs = '{2'd0, 1'b1, RF_CX};
      4'd2:    rs = '{2'd1, 1'b0, RF_SY};
      4'd3:    rs = '{2'd1, 1'b1, RF_CY};
      4'd4:    rs = '{2'd2, 1'b0, RF_SZ};
      4'd5:    rs = '{2'd2, 1'b1, RF_CZ};
      default: rs = '{2'd0, 1'b0, RF_SX};
    endcase
    return rs;
  endfunction

endpackage

/* hdl/fper_datapath.sv */
// Datapath of the Euler rotation block: sine table, operand registers,
// shared multiplier, accumulators, coefficients and result registers. Uses fper_pkg.
`timescale 1ns / 1ps
module fper_datapath
  import fper_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  input  logic [AngW-1:0]        angle_x_i,
  input  logic [AngW-1:0]        angle_y_i,
  input  logic [AngW-1:0]        angle_z_i,
  input  logic signed [VecW-1:0] vec_x_i,
  input  logic signed [VecW-1:0] vec_y_i,
  input  logic signed [VecW-1:0] vec_z_i,
  output logic signed [OutW-1:0] out_x_o,
  output logic signed [OutW-1:0] out_y_o,
  output logic signed [OutW-1:0] out_z_o
);

  localparam logic signed [OutW-1:0] Bias = OutW'((64'd1 << ScaleLog2) - 64'd1);

  logic [AngW-1:0]         ang_q [3];
  logic signed [VecW-1:0]  vec_q [3];
  logic signed [RfW-1:0]   rf_q [8];
  logic signed [CoefW-1:0] coef_q [9];
  logic signed [OutW-1:0]  acc_q [3];
  logic signed [OutW-1:0]  out_q [3];
  logic signed [OutW-1:0]  prod_q;
  logic signed [CoefW-1:0] rom_q;
  rf_sel_e                 rom_dst_q;
  logic                    rom_vld_q;

  load_step_t              ls;
  xform_step_t             xs;
  rom_step_t               rs;
  logic [RomAw-1:0]        rom_addr;
  logic signed [VecW-1:0]  op_a;
  logic signed [RfW-1:0]   op_b;
  logic signed [OutW-1:0]  mul_res;
  logic signed [OutW-1:0]  lsum;
  logic signed [OutW-1:0]  lquot;
  logic [2:0]              ang_big;

  assign ls = load_step(cmd_i.step);
  assign xs = xform_step(cmd_i.step);
  assign rs = rom_step(cmd_i.step);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ang_big[i] = 32'(ang_q[i]) >= AngleSteps;
    end
  end
  assign status_o.reduce_done = ~|ang_big;

  assign rom_addr = RomAw'(ang_q[rs.ang]) + (rs.cos ? RomAw'(Quarter) : '0);

  always_comb begin
    if (cmd_i.op == DP_XMUL) begin
      op_a = vec_q[xs.vec];
      op_b = RfW'(coef_q[cmd_i.step]);
    end else begin
      op_a = VecW'(rf_q[ls.a]);
      op_b = rf_q[ls.b];
    end
  end
  assign mul_res = op_a * op_b;

  // Division by the scale truncates toward zero, so negative sums get a bias.
  assign lsum  = (ls.first ? '0 : acc_q[0]) + (ls.neg ? -prod_q : prod_q);
  assign lquot = (lsum + (lsum[OutW-1] ? Bias : '0)) >>> ScaleLog2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_vld_q <= 1'b0;
      for (int i = 0; i < 9; i++) coef_q[i] <= '0;
    end else begin
      rom_vld_q <= (cmd_i.op == DP_ROM);
      if (rom_vld_q && rom_dst_q == RF_SX) coef_q[CoefZyIdx] <= rom_q;
      if (cmd_i.op == DP_LACC && ls.last && ls.dest != D_T1 && ls.dest != D_T2) begin
        coef_q[ls.dest] <= lquot[CoefW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q     <= SineRom[rom_addr];
    rom_dst_q <= rs.dst;
    if (rom_vld_q) rf_q[rom_dst_q] <= RfW'(rom_q);
    case (cmd_i.op)
      DP_CAPTURE: begin
        ang_q[0] <= angle_x_i;
        ang_q[1] <= angle_y_i;
        ang_q[2] <= angle_z_i;
        vec_q[0] <= vec_x_i;
        vec_q[1] <= vec_y_i;
        vec_q[2] <= vec_z_i;
      end
      DP_REDUCE: begin
        for (int i = 0; i < 3; i++) begin
          if (ang_big[i]) ang_q[i] <= ang_q[i] - AngW'(AngleSteps);
        end
      end
      DP_LMUL, DP_XMUL: begin
        prod_q <= mul_res;
      end
      DP_LACC: begin
        if (!ls.last)          acc_q[0] <= lsum;
        else if (ls.dest == D_T1) rf_q[RF_T1] <= lquot[RfW-1:0];
        else if (ls.dest == D_T2) rf_q[RF_T2] <= lquot[RfW-1:0];
      end
      DP_XACC: begin
        case (xs.vec)
          2'd0:    acc_q[xs.lane] <= prod_q;
          2'd1:    acc_q[xs.lane] <= acc_q[xs.lane] + prod_q;
          default: out_q[xs.lane] <= acc_q[xs.lane] + prod_q;
        endcase
      end
      default: ;
    endcase
  end

  assign out_x_o = out_q[0];
  assign out_y_o = out_q[1];
  assign out_z_o = out_q[2];

endmodule

/* hdl/fper_ctrl.sv */
// Controller of the Euler rotation block: request handshake and step sequencing.
// Uses fper_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "fixed_point_euler_rotate_macros.svh"
module fper_ctrl
  import fper_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  opcode_e    opcode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_REDUCE = 8'b0000_0010,
    S_ROM    = 8'b0000_0100,
    S_ROMW   = 8'b0000_1000,
    S_LMUL   = 8'b0001_0000,
    S_LACC   = 8'b0010_0000,
    S_XMUL   = 8'b0100_0000,
    S_XACC   = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept;
  logic       out_set;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    out_set   = 1'b0;
    cmd_o.op   = DP_NONE;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (in_accept) begin
          cmd_o.op = DP_CAPTURE;
          state_d  = (opcode_i == OP_LOAD) ? S_REDUCE : S_XMUL;
        end
      end
      S_REDUCE: begin
        cmd_o.op = DP_REDUCE;
        if (status_i.reduce_done) state_d = S_ROM;
      end
      S_ROM: begin
        cmd_o.op = DP_ROM;
        if (step_q == 4'(RomReads - 1)) begin
          step_d  = '0;
          state_d = S_ROMW;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_ROMW: begin
        state_d = S_LMUL;
      end
      S_LMUL: begin
        cmd_o.op = DP_LMUL;
        state_d  = S_LACC;
      end
      S_LACC: begin
        cmd_o.op = DP_LACC;
        if (step_q == 4'(LoadSteps - 1)) begin
          state_d = S_IDLE;
        end else begin
          step_d  = step_q + 4'd1;
          state_d = S_LMUL;
        end
      end
      S_XMUL: begin
        // The final sums overwrite the result registers, so wait until
        // a pending result has been taken.
        if (!(step_q == 4'(FirstFinal) && out_valid_q && !out_ready_i)) begin
          cmd_o.op = DP_XMUL;
          state_d  = S_XACC;
        end
      end
      S_XACC: begin
        cmd_o.op = DP_XACC;
        if (step_q == 4'(XformSteps - 1)) begin
          out_set = 1'b1;
          state_d = S_IDLE;
        end else begin
          step_d  = step_q + 4'd1;
          state_d = S_XMUL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_set;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FPER_ASSERT_NXT(a_busy_after_accept, in_accept, !in_ready_o,
                   "block took a request while still busy")
  `FPER_ASSERT_IMP(a_result_from_last_step, $rose(out_valid_q),
                   $past(state_q == S_XACC && step_q == 4'(XformSteps - 1)),
                   "result raised outside the final transform step")
  `FPER_ASSERT_NXT(a_load_no_result, state_q == S_LACC, !$rose(out_valid_q),
                   "load sequence produced a result")

endmodule

/* hdl/fixed_point_euler_rotate.sv */
// Top level of the fixed-point Euler rotation block (Y, X, Z order).
// Joins fper_ctrl and fper_datapath; uses fper_pkg.
`timescale 1ns / 1ps
// A load request (opcode 0) passes its three angles through a range check,
// reads sine and cosine for each from the 1280-entry sine table, and
// computes eight of the nine 16-bit coefficients with one shared 32x17
// multiplier; the ninth is copied from the table. It gives no result. A
// transform request (opcode 1) forms the three 49-bit sums from nine products
// on the same multiplier, each product being registered before it is summed.
// Requests are processed one at a time: the next is accepted only when the
// current one is finished. A finished result waits in its output register
// while the next request is accepted and computed. The seventh multiply of a
// transform is the first step that overwrites the result registers, and it
// waits until that result has been taken. Coefficients reset to zero, so a
// transform before any load returns zeros.
module fixed_point_euler_rotate
  import fper_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   opcode_i,
  input  logic [AngW-1:0]        angle_x_i,
  input  logic [AngW-1:0]        angle_y_i,
  input  logic [AngW-1:0]        angle_z_i,
  input  logic signed [VecW-1:0] vec_x_i,
  input  logic signed [VecW-1:0] vec_y_i,
  input  logic signed [VecW-1:0] vec_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] out_x_o,
  output logic signed [OutW-1:0] out_y_o,
  output logic signed [OutW-1:0] out_z_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fper_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_e'(opcode_i)),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  fper_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .angle_x_i (angle_x_i),
    .angle_y_i (angle_y_i),
    .angle_z_i (angle_z_i),
    .vec_x_i   (vec_x_i),
    .vec_y_i   (vec_y_i),
    .vec_z_i   (vec_z_i),
    .out_x_o   (out_x_o),
    .out_y_o   (out_y_o),
    .out_z_o   (out_z_o)
  );

endmodule
